[rtl/dtrs_pkg.sv]
`default_nettype none
package dtrs_pkg;

  localparam int RING_DEPTH_DEF   = 64;
  localparam int WORKER_COUNT_DEF = 8;
  // offsets at or above this mean "no link"
  localparam int OFFSET_NONE      = 64;
  // offset fields are 7 bits wide
  localparam int OFF_RANGE        = 128;
  // widest slot index over the supported ring depths
  localparam int MAX_AW           = 12;

  localparam logic [7:0] ANY_AFFINITY = 8'hFF;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_PICK = 2'd1,
    OP_DONE = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_P_START,
    S_P_RD,
    S_P_EV,
    S_P_DEV,
    S_C_START,
    S_C_EV,
    S_C_PRD,
    S_C_PEV,
    S_C_DRD,
    S_C_DEV,
    S_DONE
  } fsm_t;

  // offset modulo depth for every 7-bit offset, built at elaboration
  function automatic logic [OFF_RANGE*MAX_AW-1:0] off_mod_tbl(input int depth);
    logic [OFF_RANGE*MAX_AW-1:0] tbl;
    int r;
    tbl = '0;
    for (int i = 0; i < OFF_RANGE; i++) begin
      r = i;
      while (r >= depth) r = r - depth;
      tbl[i*MAX_AW +: MAX_AW] = MAX_AW'(r);
    end
    return tbl;
  endfunction

endpackage
`default_nettype wire

[rtl/dtrs_ram.sv]
`default_nettype none
module dtrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/dependency_task_ring_scheduler_core.sv]
`default_nettype none
// Task ring scheduler: one item in, one result out. tuser carries the opcode
// (enqueue, pick, complete); a result says ok, ring full or nothing ready.
// All task entries live in one single-port-read RAM with a registered read, so
// every item is a short sequence of read/modify/write steps: enqueue writes
// the entry, complete reads and clears the entry and then updates its parent
// and its dependency, and a pick visits the ring from head to tail, reading
// each entry and, when needed, its dependency. One item is worked at a time;
// a new item is taken while the previous result still waits in the output
// register.
module dependency_task_ring_scheduler_core #(
  parameter int RING_DEPTH   = dtrs_pkg::RING_DEPTH_DEF,
  parameter int WORKER_COUNT = dtrs_pkg::WORKER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // worker_id, pick_any_only, task_affinity, task_handle, child_refs,
  // dependent_refs, parent_offset, dependency_offset, done_slot, zero pad
  input  wire logic [79:0] in_tdata,
  // opcode
  input  wire logic [1:0]  in_tuser,
  // last_in_batch
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // slot, granted_handle, zero pad
  output logic      [39:0] out_tdata,
  // status
  output logic      [1:0]  out_tuser
);

  import dtrs_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 1;
  localparam int LW = AW + 1;
  // entry layout, lowest bits first
  localparam int F_AFF = 0;
  localparam int F_HDL = F_AFF + 8;
  localparam int F_CC  = F_HDL + 32;
  localparam int F_RUN = F_CC + 7;
  localparam int F_DC  = F_RUN + 1;
  localparam int F_PAR = F_DC + 7;
  localparam int F_DEP = F_PAR + LW;
  localparam int EW    = F_DEP + LW;

  localparam logic [OFF_RANGE*MAX_AW-1:0] OFF_TBL = off_mod_tbl(RING_DEPTH);
  localparam logic [PW:0]   D_P    = (PW+1)'(RING_DEPTH);
  localparam logic [PW:0]   D2_P   = (PW+1)'(2 * RING_DEPTH);
  localparam logic [PW-1:0] PMAX   = PW'(2 * RING_DEPTH - 1);
  localparam logic [LW-1:0] NOLINK = LW'(RING_DEPTH);

  // control registers
  fsm_t          state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] batch_r, batch_nxt;
  logic          out_valid_r, out_valid_nxt;

  // captured item
  logic [2:0]  wid_r;
  logic        any_r;
  logic [7:0]  aff_r;
  logic [31:0] hdl_r;
  logic [6:0]  cref_r, dref_r, poff_r, doff_r;
  logic        last_r;
  logic [5:0]  dslot_r;

  // scan and work registers
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] occ_r, occ_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [AW-1:0] cur_r, cur_nxt;

  // pending result and output register
  logic [1:0]  rstat_r, rstat_nxt;
  logic [5:0]  rslot_r, rslot_nxt;
  logic [31:0] rhdl_r, rhdl_nxt;
  logic [1:0]  ostat_r;
  logic [5:0]  oslot_r;
  logic [31:0] ohdl_r;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic          in_acc, out_load;
  logic [PW-1:0] occ_c;
  logic [PW:0]   diff;
  logic [AW-1:0] base, enq_slot;
  logic [AW:0]   sum_s;
  logic          full;
  logic [AW-1:0] batch_after;
  logic [PW:0]   tsum;
  logic [7:0]    mine, e_aff;
  logic          match;
  logic          adv, grant;
  logic [EW-1:0] gent;
  logic [AW-1:0] gslot;
  logic [PW-1:0] pos_inc;

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [AW-1:0] s;
    if (p >= PW'(RING_DEPTH)) s = AW'(p - PW'(RING_DEPTH));
    else s = AW'(p);
    return s;
  endfunction

  function automatic logic [LW-1:0] link_of(input logic [6:0] off, input logic [AW-1:0] b);
    logic [AW-1:0] m;
    logic [AW:0]   sm;
    logic [LW-1:0] l;
    m  = OFF_TBL[32'(off)*MAX_AW +: AW];
    sm = {1'b0, b} + {1'b0, m};
    if (sm >= (AW+1)'(RING_DEPTH)) sm = sm - (AW+1)'(RING_DEPTH);
    if (off >= 7'(OFFSET_NONE)) l = NOLINK;
    else l = LW'(sm);
    return l;
  endfunction

  dtrs_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = {2'b00, ohdl_r, oslot_r};

  // ring occupancy and enqueue arithmetic
  always_comb begin
    diff = {1'b0, tail_r} - {1'b0, head_r};
    if (diff[PW]) diff = diff + D2_P;
    occ_c = PW'(diff);
    base  = ptr_slot(tail_r);
    sum_s = {1'b0, base} + {1'b0, batch_r};
    if (sum_s >= (AW+1)'(RING_DEPTH)) sum_s = sum_s - (AW+1)'(RING_DEPTH);
    enq_slot = AW'(sum_s);
    full = ((PW+1)'(occ_c) + (PW+1)'(batch_r) + (PW+1)'(1)) >= D_P;
    batch_after = full ? batch_r : batch_r + 1'b1;
    tsum = {1'b0, tail_r} + (PW+1)'(batch_after);
    if (tsum >= D2_P) tsum = tsum - D2_P;
  end

  // affinity test of the entry being read
  always_comb begin
    mine  = (32'(wid_r) < WORKER_COUNT) ? (8'd1 << wid_r) : 8'd0;
    e_aff = rdata[F_AFF +: 8];
    match = any_r ? (e_aff == ANY_AFFINITY) : ((e_aff & mine) != 8'd0);
    pos_inc = (pos_r == PMAX) ? '0 : pos_r + 1'b1;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    batch_nxt     = batch_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    occ_nxt       = occ_r;
    ent_nxt       = ent_r;
    cur_nxt       = cur_r;
    rstat_nxt     = rstat_r;
    rslot_nxt     = rslot_r;
    rhdl_nxt      = rhdl_r;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = ent_r;
    raddr         = cur_r;
    adv           = 1'b0;
    grant         = 1'b0;
    gent          = rdata;
    gslot         = ptr_slot(pos_r);
    out_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rstat_nxt = STAT_OK;
          rslot_nxt = '0;
          rhdl_nxt  = '0;
          case (op_t'(in_tuser))
            OP_ENQ:  state_nxt = S_ENQ;
            OP_PICK: state_nxt = S_P_START;
            OP_DONE: state_nxt = S_C_START;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_ENQ: begin
        if (full) begin
          rstat_nxt = STAT_FULL;
        end else begin
          we    = 1'b1;
          waddr = enq_slot;
          wdata = '0;
          wdata[F_AFF +: 8]  = aff_r;
          wdata[F_HDL +: 32] = hdl_r;
          wdata[F_CC +: 7]   = cref_r;
          wdata[F_RUN]       = 1'b0;
          wdata[F_DC +: 7]   = dref_r;
          wdata[F_PAR +: LW] = link_of(poff_r, base);
          wdata[F_DEP +: LW] = link_of(doff_r, base);
          rslot_nxt = 6'(enq_slot);
        end
        batch_nxt = batch_after;
        if (last_r) begin
          tail_nxt  = PW'(tsum);
          batch_nxt = '0;
        end
        state_nxt = S_DONE;
      end

      S_P_START: begin
        pos_nxt = head_r;
        cnt_nxt = '0;
        occ_nxt = occ_c;
        if (occ_c == '0) begin
          rstat_nxt = STAT_EMPTY;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_P_RD;
        end
      end

      S_P_RD: begin
        raddr     = ptr_slot(pos_r);
        state_nxt = S_P_EV;
      end

      S_P_EV: begin
        ent_nxt = rdata;
        cur_nxt = ptr_slot(pos_r);
        if (!match || rdata[F_RUN] || (rdata[F_CC +: 7] > 7'd1)) begin
          adv = 1'b1;
        end else if (rdata[F_CC +: 7] == 7'd0) begin
          // finished entry at the head with no dependents leaves the ring
          if ((rdata[F_DC +: 7] == 7'd0) && (pos_r == head_r)) begin
            head_nxt = (head_r == PMAX) ? '0 : head_r + 1'b1;
          end
          adv = 1'b1;
        end else if (rdata[F_DEP +: LW] < NOLINK) begin
          raddr     = AW'(rdata[F_DEP +: LW]);
          state_nxt = S_P_DEV;
        end else begin
          grant = 1'b1;
        end
      end

      S_P_DEV: begin
        gent  = ent_r;
        gslot = cur_r;
        if ((rdata[F_CC +: 7] == 7'd0) && !rdata[F_RUN]) grant = 1'b1;
        else adv = 1'b1;
      end

      S_C_START: begin
        rslot_nxt = dslot_r;
        cur_nxt   = AW'(dslot_r);
        if (32'(dslot_r) >= RING_DEPTH) begin
          state_nxt = S_DONE;
        end else begin
          raddr     = AW'(dslot_r);
          state_nxt = S_C_EV;
        end
      end

      S_C_EV: begin
        if (!rdata[F_RUN]) begin
          state_nxt = S_DONE;
        end else begin
          ent_nxt = rdata;
          we      = 1'b1;
          waddr   = cur_r;
          wdata   = rdata;
          wdata[F_RUN]     = 1'b0;
          wdata[F_CC +: 7] = 7'd0;
          state_nxt = S_C_PRD;
        end
      end

      S_C_PRD: begin
        if (ent_r[F_PAR +: LW] < NOLINK) begin
          raddr     = AW'(ent_r[F_PAR +: LW]);
          state_nxt = S_C_PEV;
        end else begin
          state_nxt = S_C_DRD;
        end
      end

      // parent loses one child, saturating at zero
      S_C_PEV: begin
        if (rdata[F_CC +: 7] != 7'd0) begin
          we    = 1'b1;
          waddr = AW'(ent_r[F_PAR +: LW]);
          wdata = rdata;
          wdata[F_CC +: 7] = rdata[F_CC +: 7] - 7'd1;
        end
        state_nxt = S_C_DRD;
      end

      S_C_DRD: begin
        if (ent_r[F_DEP +: LW] < NOLINK) begin
          raddr     = AW'(ent_r[F_DEP +: LW]);
          state_nxt = S_C_DEV;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // dependency loses one dependent, saturating at zero
      S_C_DEV: begin
        if (rdata[F_DC +: 7] != 7'd0) begin
          we    = 1'b1;
          waddr = AW'(ent_r[F_DEP +: LW]);
          wdata = rdata;
          wdata[F_DC +: 7] = rdata[F_DC +: 7] - 7'd1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // grant: mark running and report
    if (grant) begin
      we    = 1'b1;
      waddr = gslot;
      wdata = gent;
      wdata[F_RUN] = 1'b1;
      rstat_nxt = STAT_OK;
      rslot_nxt = 6'(gslot);
      rhdl_nxt  = gent[F_HDL +: 32];
      state_nxt = S_DONE;
    end

    // step to the next ring position or give up
    if (adv) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r + 1'b1 == occ_r) begin
        rstat_nxt = STAT_EMPTY;
        state_nxt = S_DONE;
      end else begin
        pos_nxt   = pos_inc;
        state_nxt = S_P_RD;
      end
    end

    // output register
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      batch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      batch_r     <= batch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wid_r   <= in_tdata[2:0];
      any_r   <= in_tdata[3];
      aff_r   <= in_tdata[11:4];
      hdl_r   <= in_tdata[43:12];
      cref_r  <= in_tdata[50:44];
      dref_r  <= in_tdata[57:51];
      poff_r  <= in_tdata[64:58];
      doff_r  <= in_tdata[71:65];
      dslot_r <= in_tdata[77:72];
      last_r  <= in_tlast;
    end
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    occ_r   <= occ_nxt;
    ent_r   <= ent_nxt;
    cur_r   <= cur_nxt;
    rstat_r <= rstat_nxt;
    rslot_r <= rslot_nxt;
    rhdl_r  <= rhdl_nxt;
    if (out_load) begin
      ostat_r <= rstat_r;
      oslot_r <= rslot_r;
      ohdl_r  <= rhdl_r;
    end
  end

endmodule
`default_nettype wire

[dv/tb_dependency_task_ring_scheduler_core.sv]
`default_nettype none
module tb_dependency_task_ring_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dtrs_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct {
    op_t        op;
    bit [2:0]   worker;
    bit         any_only;
    bit [7:0]   affinity;
    bit [31:0]  handle;
    bit [6:0]   child_refs;
    bit [6:0]   dep_refs;
    bit [6:0]   parent_off;
    bit [6:0]   dep_off;
    bit         last;
    bit [5:0]   done_slot;
  } task_req_t;

  typedef struct {
    status_t    status;
    bit [5:0]   slot;
    bit [31:0]  handle;
  } sched_resp_t;

  // scoreboard: ring state mirror plus queue of pending responses
  class sched_scoreboard;
    bit [7:0]  aff[DEPTH];
    bit [31:0] hnd[DEPTH];
    bit [6:0]  child_cnt[DEPTH];
    bit [6:0]  dep_cnt[DEPTH];
    bit        running[DEPTH];
    bit        written[DEPTH];
    int        parent[DEPTH];
    int        depend[DEPTH];
    int        head, tail, batch_cnt;
    sched_resp_t pending[$];
    int        errors, n_in, n_out, n_full, n_grant, n_empty;

    function int link_slot(bit [6:0] off, int base);
      if (off >= OFFSET_NONE) return DEPTH;
      return (base + off) % DEPTH;
    endfunction

    function bit finished(int s);
      return child_cnt[s] == 0 && !running[s];
    endfunction

    function int occupancy();
      return (tail + 2*DEPTH - head) % (2*DEPTH);
    endfunction

    function sched_resp_t predict(task_req_t r);
      sched_resp_t o;
      int base, s, pos, d, start, occ;
      bit [7:0] mine;
      o.status = STAT_OK; o.slot = '0; o.handle = '0;
      case (r.op)
        OP_ENQ: begin
          occ = occupancy();
          if (occ + batch_cnt + 1 >= DEPTH) begin
            o.status = STAT_FULL;
          end else begin
            base = tail % DEPTH;
            s = (base + batch_cnt) % DEPTH;
            aff[s] = r.affinity; hnd[s] = r.handle;
            child_cnt[s] = r.child_refs; dep_cnt[s] = r.dep_refs;
            running[s] = 0; written[s] = 1;
            parent[s] = link_slot(r.parent_off, base);
            depend[s] = link_slot(r.dep_off, base);
            batch_cnt++;
            o.slot = 6'(s);
          end
          if (r.last) begin
            tail = (tail + batch_cnt) % (2*DEPTH);
            batch_cnt = 0;
          end
        end
        OP_PICK: begin
          o.status = STAT_EMPTY;
          start = head;
          occ = occupancy();
          mine = 8'(1) << r.worker;
          for (int i = 0; i < occ; i++) begin
            pos = (start + i) % (2*DEPTH);
            s = pos % DEPTH;
            if (r.any_only ? (aff[s] != ANY_AFFINITY) : ((aff[s] & mine) == 0)) continue;
            if (running[s] || child_cnt[s] > 1) continue;
            if (child_cnt[s] == 0) begin
              // finished entry: retire when at head and nothing depends on it
              if (dep_cnt[s] == 0 && pos == head) head = (head + 1) % (2*DEPTH);
              continue;
            end
            d = depend[s];
            if (d < DEPTH && !finished(d)) continue;
            running[s] = 1;
            o.status = STAT_OK; o.slot = 6'(s); o.handle = hnd[s];
            break;
          end
        end
        OP_DONE: begin
          s = int'(r.done_slot);
          o.slot = 6'(s);
          if (running[s]) begin
            running[s] = 0;
            child_cnt[s] = 0;
            if (parent[s] < DEPTH && child_cnt[parent[s]] > 0) child_cnt[parent[s]]--;
            if (depend[s] < DEPTH && dep_cnt[depend[s]] > 0) dep_cnt[depend[s]]--;
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_input(task_req_t r);
      sched_resp_t o;
      o = predict(r);
      n_in++;
      if (o.status == STAT_FULL) n_full++;
      if (r.op == OP_PICK && o.status == STAT_OK) n_grant++;
      if (o.status == STAT_EMPTY) n_empty++;
      pending.push_back(o);
    endfunction

    function void check_result(status_t st, bit [5:0] slot, bit [31:0] h);
      sched_resp_t e;
      n_out++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response status %0d slot %0d", $realtime, st, slot);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st != e.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, e.status, st); errors++;
      end
      if (slot != e.slot) begin
        $display("%0t: slot exp %0d got %0d", $realtime, e.slot, slot); errors++;
      end
      if (h != e.handle) begin
        $display("%0t: handle exp %h got %h", $realtime, e.handle, h); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  sched_scoreboard sb = new;
  bit idle_on = 1;
  int hold_left = 0;
  bit held = 0;
  int quiet_cycles = 0;

  dependency_task_ring_scheduler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // send one item and record it once accepted
  task automatic send(task_req_t r);
    in_tuser <= r.op;
    in_tlast <= r.last;
    in_tdata <= {2'b0, r.done_slot, r.dep_off, r.parent_off, r.dep_refs, r.child_refs,
                 r.handle, r.affinity, r.any_only, r.worker};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(r);
    if (idle_on && $urandom_range(99) < 20) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
  endtask

  function automatic task_req_t blank(op_t op);
    task_req_t r;
    r.op = op; r.worker = 0; r.any_only = 0; r.affinity = 8'hFF; r.handle = '0;
    r.child_refs = 1; r.dep_refs = 0; r.parent_off = 7'd64; r.dep_off = 7'd64;
    r.last = 1; r.done_slot = 0;
    return r;
  endfunction

  // offset toward an already written slot, else no link
  function automatic bit [6:0] pick_offset(int idx);
    int base, o;
    base = sb.tail % DEPTH;
    if ($urandom_range(99) < 40) return 7'($urandom_range(64, 127));
    if ($urandom_range(1) && idx > 0) return 7'($urandom_range(idx - 1));
    o = $urandom_range(63);
    if (sb.written[(base + o) % DEPTH] &&
        !(o >= idx && o < idx + 1 + 0 && 0)) begin
      if (o < sb.batch_cnt || (o >= sb.batch_cnt && sb.written[(base + o) % DEPTH]))
        return 7'(o);
    end
    return 7'd127;
  endfunction

  function automatic task_req_t rand_enq(int idx, bit last);
    task_req_t r;
    r = blank(OP_ENQ);
    r.worker = 3'($urandom); r.any_only = 1'($urandom);
    r.affinity = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
    r.handle = $urandom;
    case ($urandom_range(9))
      0: r.child_refs = 0;
      1: r.child_refs = 2;
      2: r.child_refs = 7'($urandom_range(64));
      default: r.child_refs = 1;
    endcase
    r.dep_refs = ($urandom_range(19) == 0) ? 7'($urandom_range(64)) : 7'd0;
    r.parent_off = pick_offset(idx);
    r.dep_off = pick_offset(idx);
    r.last = last;
    r.done_slot = 6'($urandom);
    return r;
  endfunction

  function automatic task_req_t rand_done();
    task_req_t r;
    int cands[$];
    r = blank(OP_DONE);
    r.worker = 3'($urandom); r.handle = $urandom; r.affinity = 8'($urandom);
    for (int s = 0; s < DEPTH; s++)
      if ($urandom_range(99) < 75 ? sb.running[s] : sb.written[s]) cands.push_back(s);
    if (cands.size() == 0)
      for (int s = 0; s < DEPTH; s++) if (sb.written[s]) cands.push_back(s);
    if (cands.size() == 0) return blank(OP_NOP);
    r.done_slot = 6'(cands[$urandom_range(cands.size() - 1)]);
    r.last = 1'($urandom);
    return r;
  endfunction

  function automatic task_req_t rand_pick();
    task_req_t r;
    r = blank(OP_PICK);
    r.worker = 3'($urandom);
    r.any_only = ($urandom_range(4) == 0);
    r.handle = $urandom; r.affinity = 8'($urandom); r.last = 1'($urandom);
    return r;
  endfunction

  // stimulus
  initial begin
    task_req_t r;
    int nb;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty pick, stray complete, unused opcode, field extremes
    send(blank(OP_PICK));
    r = blank(OP_NOP); r.handle = '1; r.worker = 7; send(r);
    r = blank(OP_ENQ); r.last = 0; r.handle = 32'hFFFF_FFFF; r.child_refs = 2; send(r);
    r = blank(OP_ENQ); r.last = 0; r.handle = 0; r.affinity = 8'h01;
    r.parent_off = 0; r.dep_off = 7'd127; send(r);
    r = blank(OP_ENQ); r.last = 1; r.handle = 32'h5A5A_A5A5; r.affinity = 8'h80;
    r.dep_off = 1; r.dep_refs = 0; send(r);
    r = blank(OP_PICK); r.any_only = 1; send(r);
    r = blank(OP_PICK); r.worker = 7; send(r);
    r = blank(OP_PICK); r.worker = 0; send(r);
    r = blank(OP_DONE); r.done_slot = 1; send(r);
    r = blank(OP_PICK); r.worker = 7; send(r);
    r = blank(OP_PICK); r.worker = 0; r.any_only = 1; send(r);
    r = blank(OP_DONE); r.done_slot = 0; send(r);
    r = blank(OP_DONE); r.done_slot = 0; send(r);
    r = blank(OP_ENQ); r.affinity = 0; r.child_refs = 64; r.dep_refs = 64; send(r);
    r = blank(OP_PICK); r.worker = 3; send(r);
    r = blank(OP_ENQ); r.affinity = 8'hFF; r.child_refs = 0; r.dep_refs = 1; r.dep_off = 7'd64;
    send(r);

    // random: batches, picks and completes
    while (sb.n_in < 620) begin
      if (sb.n_in > 220 && sb.n_in < 360) idle_on = 0;
      else idle_on = 1;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          nb = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
          for (int i = 0; i < nb; i++) send(rand_enq(i, i == nb - 1));
        end
        4, 5, 6: send(rand_pick());
        7, 8: send(rand_done());
        default: begin
          if ($urandom_range(3) == 0) send(blank(OP_NOP));
          else send(rand_enq(0, 1));
        end
      endcase
    end
    in_tvalid <= 0;

    wait (sb.pending.size() == 0);
    repeat (300) @(posedge clk);
    $display("Ran %0d items, %0d responses: %0d grants, %0d ring-full, %0d nothing-ready.",
             sb.n_in, sb.n_out, sb.n_grant, sb.n_full, sb.n_empty);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_dependency_task_ring_scheduler_core OK");
    else
      $display("tb_dependency_task_ring_scheduler_core NOT OK");
    $finish;
  end

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else if (!held && sb.n_out >= 150) begin
      held <= 1;
      hold_left <= 400;
      out_tready <= 0;
    end else begin
      out_tready <= !idle_on || ($urandom_range(99) >= 20);
    end
  end

  // response check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(status_t'(out_tuser), out_tdata[5:0], out_tdata[37:6]);
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("tb_dependency_task_ring_scheduler_core NOT OK");
      $finish;
    end
  end
endmodule
`default_nettype wire

[filelist.f]
rtl/dtrs_pkg.sv
rtl/dtrs_ram.sv
rtl/dependency_task_ring_scheduler_core.sv
dv/tb_dependency_task_ring_scheduler_core.sv
